### hw/rtl/lnl_pkg.sv
`default_nettype none
package lnl_pkg;

	localparam int MAX_CH     = 8;
	localparam int CH_W       = $clog2(MAX_CH);
	localparam int LA_DEPTH   = 128;
	localparam int SLOT_W     = $clog2(LA_DEPTH);
	localparam int BOOST_HOLD = 5;
	localparam int SAMPLE_W   = 24;
	localparam int DLY_W      = 26;
	localparam int DVD_W      = 64;
	localparam int DVS_W      = 56;

	localparam int UNITY = 1048576;

	localparam logic [24:0] COEF_ONE   = 25'd16777216;
	localparam logic [31:0] ABS_GATE   = 32'd6790;
	localparam logic [21:0] MIN_GAIN   = 22'd104858;
	localparam logic [21:0] MAX_GAIN   = 22'd4174456;
	localparam logic [24:0] DZ_HI      = 25'd18824346;
	localparam logic [24:0] DZ_LO      = 25'd14952710;
	localparam logic [23:0] BLOCKS_MAX = 24'hFFFFFF;
	localparam logic [63:0] GOAL_NUM   = 64'd1767583545025 << 23;
	localparam logic [63:0] Q_LIMIT    = 64'd1 << 44;

	// register indexes
	localparam logic [2:0] REG_ENABLE  = 3'd0;
	localparam logic [2:0] REG_CHANS   = 3'd1;
	localparam logic [2:0] REG_LOOK    = 3'd2;
	localparam logic [2:0] REG_BLOCK   = 3'd3;
	localparam logic [2:0] REG_ATTACK  = 3'd4;
	localparam logic [2:0] REG_RELEASE = 3'd5;
	localparam logic [2:0] REG_MAKEUP  = 3'd6;
	localparam logic [2:0] REG_CEIL    = 3'd7;

	typedef struct packed {
		logic        enable;
		logic [3:0]  chans;
		logic [7:0]  look;
		logic [19:0] block;
		logic [24:0] attack;
		logic [24:0] release_c;
		logic [24:0] makeup;
		logic [22:0] ceil_lvl;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		enable:    1'b0,
		chans:     4'd2,
		look:      8'd88,
		block:     20'd17640,
		attack:    25'd376160,
		release_c: 25'd3170,
		makeup:    25'd951,
		ceil_lvl:  23'd7476355
	};

	typedef enum logic [1:0] {
		K_FRAME,
		K_TRACK,
		K_TRANSPORT,
		K_IGNORE
	} kind_t;

	typedef logic [MAX_CH-1:0][SAMPLE_W-1:0] frame_t;

	typedef struct packed {
		kind_t  kind;
		frame_t samples;
	} item_t;

endpackage
`default_nettype wire

### hw/rtl/lnl_front.sv
`default_nettype none
module lnl_front import lnl_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output logic       item_stall,
	input  wire  [1:0] cmd,
	input  frame_t     samples,
	output logic       head_valid,
	output item_t      head,
	input  wire        head_pop
);

	item_t      q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	kind_t      kind;
	logic       push;

	always_comb begin
		unique case (cmd)
			2'd0: kind = K_FRAME;
			2'd1: kind = K_TRACK;
			2'd2: kind = K_TRANSPORT;
			default: kind = K_IGNORE;
		endcase
	end

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{kind: kind, samples: samples};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (head_pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, head_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lnl_div.sv
`default_nettype none
module lnl_div import lnl_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire  [DVD_W-1:0]       dividend,
	input  wire  [DVS_W-1:0]       divisor,
	output logic                   busy,
	output logic [DVD_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	assign busy     = busy_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q   <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			dq_q   <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			cnt_q  <= CNT_W'(DVD_W);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lnl_back.sv
`default_nettype none
module lnl_back import lnl_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  cfg_t       cfg,
	input  wire        head_valid,
	input  item_t      head,
	output logic       head_pop,
	output logic       result_valid,
	input  wire        result_stall,
	output frame_t     result
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SQ    = 5'd1;
	localparam logic [4:0] S_SQA   = 5'd2;
	localparam logic [4:0] S_D1    = 5'd3;
	localparam logic [4:0] S_D1W   = 5'd4;
	localparam logic [4:0] S_D2    = 5'd5;
	localparam logic [4:0] S_D2W   = 5'd6;
	localparam logic [4:0] S_GT    = 5'd7;
	localparam logic [4:0] S_GTA   = 5'd8;
	localparam logic [4:0] S_ACC   = 5'd9;
	localparam logic [4:0] S_D3    = 5'd10;
	localparam logic [4:0] S_D3W   = 5'd11;
	localparam logic [4:0] S_D4    = 5'd12;
	localparam logic [4:0] S_D4W   = 5'd13;
	localparam logic [4:0] S_SQRT  = 5'd14;
	localparam logic [4:0] S_CLAMP = 5'd15;
	localparam logic [4:0] S_DZ1   = 5'd16;
	localparam logic [4:0] S_DZ2   = 5'd17;
	localparam logic [4:0] S_DZ3   = 5'd18;
	localparam logic [4:0] S_MK    = 5'd19;
	localparam logic [4:0] S_MKA   = 5'd20;
	localparam logic [4:0] S_MG    = 5'd21;
	localparam logic [4:0] S_MGA   = 5'd22;
	localparam logic [4:0] S_LIM   = 5'd23;
	localparam logic [4:0] S_LIMW  = 5'd24;
	localparam logic [4:0] S_LS    = 5'd25;
	localparam logic [4:0] S_LSA   = 5'd26;
	localparam logic [4:0] S_OM    = 5'd27;
	localparam logic [4:0] S_OA    = 5'd28;
	localparam logic [4:0] S_WR    = 5'd29;
	localparam logic [4:0] S_OUT   = 5'd30;

	typedef logic [MAX_CH-1:0][DLY_W-1:0] row_t;

	logic [4:0]                 state_q;
	logic signed [SAMPLE_W-1:0] smp_q [MAX_CH];
	logic [CH_W-1:0]            ch_q;
	logic [49:0]                sumsq_q;
	logic [51:0]                be_q;
	logic [19:0]                fill_q;
	logic [55:0]                integ_q;
	logic [23:0]                gated_q;
	logic [21:0]                goal_q;
	logic [21:0]                mk_q;
	logic [20:0]                lg_q;
	logic                       prev_en_q;
	logic [31:0]                mean_q;
	logic [21:0]                g_q;
	logic                       hi_lt_q;
	logic [47:0]                sr_q;
	logic [47:0]                sv_q;
	logic [47:0]                sb_q;
	logic [25:0]                peak_q;
	logic signed [DLY_W-1:0]    sm_q [MAX_CH];
	logic [20:0]                des_q;
	logic [LA_DEPTH-1:0]        row_vld_q;
	logic                       rd_vld_q;
	row_t                       rd_q;
	row_t                       dly_mem [LA_DEPTH];
	logic [SLOT_W-1:0]          slot_q;
	logic [SAMPLE_W-1:0]        res_q [MAX_CH];
	frame_t                     out_q;
	logic                       out_vld_q;
	logic signed [65:0]         mul_p_q;

	// clamped configuration
	logic [3:0]  nc;
	logic [CH_W-1:0] nc_m1;
	logic [7:0]  look;
	logic [19:0] bf;
	logic [24:0] atk;
	logic [24:0] rel;
	logic [24:0] mkc;

	logic signed [32:0]         mul_a;
	logic signed [32:0]         mul_b;
	logic                       div_start;
	logic [DVD_W-1:0]           div_dvd;
	logic [DVS_W-1:0]           div_dvs;
	logic                       div_busy;
	logic [DVD_W-1:0]           div_quo;

	logic                       last_ch;
	logic                       clr_trk;
	logic                       clr_trn;
	logic                       out_free;
	logic [51:0]                be_add;
	logic [19:0]                fill_inc;
	logic [59:0]                p10;
	logic [47:0]                sq_trial;
	logic [21:0]                g_clamp;
	logic [47:0]                g_sh;
	logic signed [65:0]         rnd20;
	logic signed [65:0]         sh20;
	logic signed [65:0]         rnd24;
	logic signed [65:0]         sh24;
	logic signed [25:0]         mk_sum;
	logic signed [25:0]         lg_sum;
	logic signed [22:0]         diff_mk;
	logic signed [21:0]         diff_lg;
	logic [24:0]                coef_lg;
	logic signed [SAMPLE_W-1:0] smp_cur;
	logic signed [DLY_W-1:0]    d_cur;
	logic signed [DLY_W-1:0]    sm_new;
	logic [25:0]                sm_abs;
	logic signed [26:0]         y_raw;
	logic signed [26:0]         ceil_s;
	logic signed [26:0]         y_cl;
	logic [SLOT_W:0]            slot_inc;
	logic [SLOT_W-1:0]          slot_next;
	row_t                       wr_row;

	always_comb begin
		nc    = (cfg.chans == 4'd0) ? 4'd1 :
		        (cfg.chans > 4'(MAX_CH)) ? 4'(MAX_CH) : cfg.chans;
		nc_m1 = CH_W'(nc - 4'd1);
		look  = (cfg.look == 8'd0) ? 8'd1 :
		        (cfg.look > 8'(LA_DEPTH)) ? 8'(LA_DEPTH) : cfg.look;
		bf    = (cfg.block == 20'd0) ? 20'd1 : cfg.block;
		atk   = (cfg.attack > COEF_ONE) ? COEF_ONE : cfg.attack;
		rel   = (cfg.release_c > COEF_ONE) ? COEF_ONE : cfg.release_c;
		mkc   = (cfg.makeup > COEF_ONE) ? COEF_ONE : cfg.makeup;
	end

	assign last_ch  = (ch_q == nc_m1);
	assign clr_trk  = (cfg.enable != prev_en_q) || (head.kind == K_TRACK);
	assign clr_trn  = clr_trk || (head.kind == K_TRANSPORT);
	assign head_pop = (state_q == S_IDLE) && head_valid;
	assign out_free = !out_vld_q || !result_stall;

	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_comb begin
		smp_cur  = smp_q[ch_q];
		d_cur    = rd_vld_q ? $signed(rd_q[ch_q]) : '0;
		diff_mk  = $signed({1'b0, goal_q}) - $signed({1'b0, mk_q});
		diff_lg  = $signed({1'b0, des_q}) - $signed({1'b0, lg_q});
		coef_lg  = (des_q < lg_q) ? atk : rel;
		be_add   = be_q + 52'(div_quo[49:15]);
		fill_inc = fill_q + 20'd1;
		p10      = 60'({mul_p_q[55:0], 3'b000}) + 60'({mul_p_q[55:0], 1'b0});
		sq_trial = sr_q + sb_q;
		g_sh     = 48'({g_q, 24'd0});
		// round half up then drop the fraction bits
		rnd20    = mul_p_q + 66'sd524288;
		sh20     = rnd20 >>> 20;
		rnd24    = mul_p_q + 66'sd8388608;
		sh24     = rnd24 >>> 24;
		mk_sum   = $signed({4'd0, mk_q}) + $signed(sh24[25:0]);
		lg_sum   = $signed({5'd0, lg_q}) + $signed(sh24[25:0]);
		sm_new   = $signed(sh20[DLY_W-1:0]);
		sm_abs   = sm_new[DLY_W-1] ? 26'(-sm_new) : 26'(sm_new);
		y_raw    = $signed(sh20[26:0]);
		ceil_s   = $signed({4'd0, cfg.ceil_lvl});
		if (y_raw > ceil_s) y_cl = ceil_s;
		else if (y_raw < -ceil_s) y_cl = -ceil_s;
		else y_cl = y_raw;
		slot_inc  = {1'b0, slot_q} + (SLOT_W+1)'(1);
		slot_next = (9'(slot_inc) >= 9'(look)) ? '0 : slot_inc[SLOT_W-1:0];
	end

	always_comb begin
		if (sr_q < 48'(MIN_GAIN)) g_clamp = MIN_GAIN;
		else if (sr_q > 48'(MAX_GAIN)) g_clamp = MAX_GAIN;
		else g_clamp = sr_q[21:0];
		// no boost until enough blocks are in
		if (g_clamp > 22'(UNITY) && gated_q < 24'(BOOST_HOLD)) g_clamp = 22'(UNITY);
	end

	always_comb begin
		for (int c = 0; c < MAX_CH; c++) begin
			if (4'(c) < nc) wr_row[c] = sm_q[c];
			else wr_row[c] = rd_vld_q ? rd_q[c] : '0;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = 33'(smp_cur);
				mul_b = 33'(smp_cur);
			end
			S_GT: begin
				mul_a = 33'(mean_q);
				mul_b = 33'(gated_q);
			end
			S_DZ1: begin
				mul_a = 33'(goal_q);
				mul_b = 33'(DZ_HI);
			end
			S_DZ2: begin
				mul_a = 33'(goal_q);
				mul_b = 33'(DZ_LO);
			end
			S_MK: begin
				mul_a = 33'(diff_mk);
				mul_b = 33'(mkc);
			end
			S_MG: begin
				mul_a = 33'(smp_cur);
				mul_b = 33'(mk_q);
			end
			S_LS: begin
				mul_a = 33'(diff_lg);
				mul_b = 33'(coef_lg);
			end
			S_OM: begin
				mul_a = 33'(d_cur);
				mul_b = 33'(lg_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			S_D1: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(sumsq_q);
				div_dvs   = DVS_W'(nc);
			end
			S_D2: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(be_q);
				div_dvs   = DVS_W'(fill_q);
			end
			S_D3: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(integ_q);
				div_dvs   = DVS_W'(gated_q);
			end
			S_D4: begin
				div_start = 1'b1;
				div_dvd   = GOAL_NUM;
				div_dvs   = div_quo[DVS_W-1:0];
			end
			S_LIM: begin
				div_start = (peak_q > 26'(cfg.ceil_lvl));
				div_dvd   = DVD_W'({cfg.ceil_lvl, 20'd0});
				div_dvs   = DVS_W'(peak_q);
			end
			default: begin
				div_start = 1'b0;
				div_dvd   = '0;
				div_dvs   = '0;
			end
		endcase
	end

	lnl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (state_q == S_LS) rd_q <= dly_mem[slot_q];
		if (state_q == S_WR) dly_mem[slot_q] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ch_q      <= '0;
			sumsq_q   <= '0;
			be_q      <= '0;
			fill_q    <= '0;
			integ_q   <= '0;
			gated_q   <= '0;
			goal_q    <= 22'(UNITY);
			mk_q      <= 22'(UNITY);
			lg_q      <= 21'(UNITY);
			prev_en_q <= 1'b0;
			mean_q    <= '0;
			g_q       <= '0;
			hi_lt_q   <= 1'b0;
			sr_q      <= '0;
			sv_q      <= '0;
			sb_q      <= '0;
			peak_q    <= '0;
			des_q     <= '0;
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			slot_q    <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
			for (int c = 0; c < MAX_CH; c++) begin
				smp_q[c] <= '0;
				sm_q[c]  <= '0;
				res_q[c] <= '0;
			end
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						for (int c = 0; c < MAX_CH; c++) begin
							smp_q[c] <= $signed(head.samples[c]);
						end
						if (clr_trn) begin
							row_vld_q <= '0;
							slot_q    <= '0;
							lg_q      <= 21'(UNITY);
							be_q      <= '0;
							fill_q    <= '0;
						end
						if (clr_trk) begin
							integ_q <= '0;
							gated_q <= '0;
							goal_q  <= 22'(UNITY);
							mk_q    <= 22'(UNITY);
						end
						prev_en_q <= cfg.enable;
						if (head.kind == K_FRAME) begin
							if (!cfg.enable) begin
								for (int c = 0; c < MAX_CH; c++) begin
									res_q[c] <= head.samples[c];
								end
								state_q <= S_OUT;
							end else begin
								ch_q    <= '0;
								sumsq_q <= '0;
								state_q <= S_SQ;
							end
						end
					end
				end
				S_SQ: state_q <= S_SQA;
				S_SQA: begin
					sumsq_q <= sumsq_q + mul_p_q[49:0];
					if (last_ch) begin
						state_q <= S_D1;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_SQ;
					end
				end
				S_D1: state_q <= S_D1W;
				S_D1W: begin
					if (!div_busy) begin
						be_q   <= be_add;
						fill_q <= fill_inc;
						state_q <= (fill_inc >= bf) ? S_D2 : S_MK;
					end
				end
				S_D2: state_q <= S_D2W;
				S_D2W: begin
					if (!div_busy) begin
						mean_q <= div_quo[31:0];
						be_q   <= '0;
						fill_q <= '0;
						priority if (div_quo[31:0] <= ABS_GATE || gated_q >= BLOCKS_MAX) begin
							state_q <= S_MK;
						end else if (gated_q != 24'd0) begin
							state_q <= S_GT;
						end else begin
							state_q <= S_ACC;
						end
					end
				end
				S_GT: state_q <= S_GTA;
				S_GTA: state_q <= (p10 < 60'(integ_q)) ? S_MK : S_ACC;
				S_ACC: begin
					integ_q <= integ_q + 56'(mean_q);
					gated_q <= gated_q + 24'd1;
					state_q <= S_D3;
				end
				S_D3: state_q <= S_D3W;
				S_D3W: begin
					if (!div_busy) begin
						state_q <= (div_quo[DVS_W-1:0] == '0) ? S_MK : S_D4;
					end
				end
				S_D4: state_q <= S_D4W;
				S_D4W: begin
					if (!div_busy) begin
						if (div_quo >= Q_LIMIT) begin
							sr_q    <= 48'(MAX_GAIN);
							state_q <= S_CLAMP;
						end else begin
							sv_q    <= 48'({div_quo[43:0], 2'b00});
							sr_q    <= '0;
							sb_q    <= 48'd1 << 46;
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					// two bits of the radicand per step
					if (sv_q >= sq_trial) begin
						sv_q <= sv_q - sq_trial;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q <= sb_q >> 2;
					if (sb_q == 48'd1) state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					g_q     <= g_clamp;
					state_q <= S_DZ1;
				end
				S_DZ1: state_q <= S_DZ2;
				S_DZ2: begin
					hi_lt_q <= (g_sh < mul_p_q[47:0]);
					state_q <= S_DZ3;
				end
				S_DZ3: begin
					// inside the dead zone the goal stays
					if (!(hi_lt_q && (g_sh > mul_p_q[47:0]))) goal_q <= g_q;
					state_q <= S_MK;
				end
				S_MK: state_q <= S_MKA;
				S_MKA: begin
					mk_q    <= mk_sum[21:0];
					ch_q    <= '0;
					peak_q  <= '0;
					state_q <= S_MG;
				end
				S_MG: state_q <= S_MGA;
				S_MGA: begin
					sm_q[ch_q] <= sm_new;
					if (sm_abs > peak_q) peak_q <= sm_abs;
					if (last_ch) begin
						state_q <= S_LIM;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_MG;
					end
				end
				S_LIM: begin
					if (peak_q > 26'(cfg.ceil_lvl)) begin
						state_q <= S_LIMW;
					end else begin
						des_q   <= 21'(UNITY);
						state_q <= S_LS;
					end
				end
				S_LIMW: begin
					if (!div_busy) begin
						des_q   <= div_quo[20:0];
						state_q <= S_LS;
					end
				end
				S_LS: begin
					rd_vld_q <= row_vld_q[slot_q];
					for (int c = 0; c < MAX_CH; c++) begin
						res_q[c] <= '0;
					end
					state_q <= S_LSA;
				end
				S_LSA: begin
					lg_q    <= lg_sum[20:0];
					ch_q    <= '0;
					state_q <= S_OM;
				end
				S_OM: state_q <= S_OA;
				S_OA: begin
					res_q[ch_q] <= y_cl[SAMPLE_W-1:0];
					if (last_ch) begin
						state_q <= S_WR;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_OM;
					end
				end
				S_WR: begin
					row_vld_q[slot_q] <= 1'b1;
					slot_q  <= slot_next;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						for (int c = 0; c < MAX_CH; c++) begin
							out_q[c] <= res_q[c];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/loudness_normaliser_lookahead_limiter.sv
// path: bypass frames pass the queue and output register; processed frames also run the
//   sequencer, plus a divide when the limiter acts and the gating and gain steps at a block end
// throughput: one frame at a time in the back end, set by the 64-step shared divider
// commands other than frames retire from the queue without a sequencer pass and give no result
// reset: asynchronous active low; registers take their defaults, control state cleared,
//   look-ahead rows marked empty through valid bits, no clearing pass
`default_nettype none
module loudness_normaliser_lookahead_limiter import lnl_pkg::*; (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration writes
	input  wire                        cfg_write_en,
	input  wire  [2:0]                 cfg_index,
	input  wire  [24:0]                cfg_data,
	// request side
	input  wire                        item_valid,
	output logic                       item_stall,
	input  wire  [1:0]                 cmd,
	input  wire  signed [SAMPLE_W-1:0] sample_ch0,
	input  wire  signed [SAMPLE_W-1:0] sample_ch1,
	input  wire  signed [SAMPLE_W-1:0] sample_ch2,
	input  wire  signed [SAMPLE_W-1:0] sample_ch3,
	input  wire  signed [SAMPLE_W-1:0] sample_ch4,
	input  wire  signed [SAMPLE_W-1:0] sample_ch5,
	input  wire  signed [SAMPLE_W-1:0] sample_ch6,
	input  wire  signed [SAMPLE_W-1:0] sample_ch7,
	// result side
	output logic                       result_valid,
	input  wire                        result_stall,
	output logic signed [SAMPLE_W-1:0] out_ch0,
	output logic signed [SAMPLE_W-1:0] out_ch1,
	output logic signed [SAMPLE_W-1:0] out_ch2,
	output logic signed [SAMPLE_W-1:0] out_ch3,
	output logic signed [SAMPLE_W-1:0] out_ch4,
	output logic signed [SAMPLE_W-1:0] out_ch5,
	output logic signed [SAMPLE_W-1:0] out_ch6,
	output logic signed [SAMPLE_W-1:0] out_ch7
);

	cfg_t   cfg_q;
	frame_t samples;
	frame_t result;
	item_t  head;
	logic   head_valid;
	logic   head_pop;

	// register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_ENABLE:  cfg_q.enable    <= cfg_data[0];
				REG_CHANS:   cfg_q.chans     <= cfg_data[3:0];
				REG_LOOK:    cfg_q.look      <= cfg_data[7:0];
				REG_BLOCK:   cfg_q.block     <= cfg_data[19:0];
				REG_ATTACK:  cfg_q.attack    <= cfg_data;
				REG_RELEASE: cfg_q.release_c <= cfg_data;
				REG_MAKEUP:  cfg_q.makeup    <= cfg_data;
				REG_CEIL:    cfg_q.ceil_lvl  <= cfg_data[22:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	assign samples = {sample_ch7, sample_ch6, sample_ch5, sample_ch4,
	                  sample_ch3, sample_ch2, sample_ch1, sample_ch0};

	// front end: classify the command and park the request in a two-deep queue
	lnl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.samples    (samples),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	// back end: sequencer with shared multiplier, divider, square root and
	// the look-ahead memory; results leave through its output register
	lnl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.head_pop     (head_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign out_ch0 = $signed(result[0]);
	assign out_ch1 = $signed(result[1]);
	assign out_ch2 = $signed(result[2]);
	assign out_ch3 = $signed(result[3]);
	assign out_ch4 = $signed(result[4]);
	assign out_ch5 = $signed(result[5]);
	assign out_ch6 = $signed(result[6]);
	assign out_ch7 = $signed(result[7]);

endmodule
`default_nettype wire

### hw/rtl/lnl_checker.sv
`default_nettype none
module lnl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        item_valid,
	input wire        item_stall,
	input wire [1:0]  cmd,
	input wire        result_valid,
	input wire        result_stall,
	input wire [23:0] out_ch0,
	input wire [23:0] out_ch7
);

	localparam logic [1:0] CMD_FRAME = 2'd0;

	logic [2:0] pend_q;
	logic       frame_in;
	logic       res_out;

	assign frame_in = item_valid && !item_stall && (cmd == CMD_FRAME);
	assign res_out  = result_valid && !result_stall;

	// frames taken in and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b00, frame_in} - {2'b00, res_out};
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(out_ch0) && $stable(out_ch7))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_out |-> pend_q != 3'd0)
		else $error("result without a frame");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid out of reset");

endmodule

bind loudness_normaliser_lookahead_limiter lnl_checker u_chk (.*);
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;
	import lnl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// cycle budget: the worst frame plus stalls, taken several times over
	localparam int CYCLE_LIMIT = 3000000;
	// quiet time before a register write, longer than the slowest frame with a block end
	localparam int SETTLE = 600;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 108;

	// bit-exact prediction of the normaliser and limiter plus the queue of expected frames
	class loudness_checker;
		cfg_t regs;
		longint dly [LA_DEPTH*MAX_CH];
		int unsigned wslot, fill, nblk;
		longint lim_gain, goal, mk_gain;
		longint unsigned blk_e, integ;
		bit prev_en;
		frame_t pending_frames [$];
		int errors, frames_in, frames_out, track_clears, transport_clears, blocks_kept;

		function new();
			regs = CFG_RESET;
			prev_en = 0;
			clear_track();
		endfunction

		function void set_reg(logic [2:0] idx, logic [24:0] v);
			case (idx)
				REG_ENABLE:  regs.enable = v[0];
				REG_CHANS:   regs.chans = v[3:0];
				REG_LOOK:    regs.look = v[7:0];
				REG_BLOCK:   regs.block = v[19:0];
				REG_ATTACK:  regs.attack = v;
				REG_RELEASE: regs.release_c = v;
				REG_MAKEUP:  regs.makeup = v;
				REG_CEIL:    regs.ceil_lvl = v[22:0];
			endcase
		endfunction

		function void clear_transport();
			foreach (dly[i]) dly[i] = 0;
			wslot = 0;
			lim_gain = UNITY;
			blk_e = 0;
			fill = 0;
		endfunction

		function void clear_track();
			clear_transport();
			integ = 0;
			nblk = 0;
			goal = UNITY;
			mk_gain = UNITY;
		endfunction

		// round half up, arithmetic shift
		function longint rnd_shift(longint p, int sh);
			return (p + (longint'(1) <<< (sh - 1))) >>> sh;
		endfunction

		function longint one_pole(longint cur, longint tgt, longint coef);
			return cur + rnd_shift((tgt - cur) * coef, 24);
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void retarget_gain();
			longint unsigned e, q, gu;
			longint g;
			if (nblk == 0) return;
			e = integ / nblk;
			if (e == 0) return;
			q = GOAL_NUM / e;
			if (q >= Q_LIMIT) g = MAX_GAIN;
			else g = longint'(int_sqrt(q << 2));
			if (g < MIN_GAIN) g = MIN_GAIN;
			if (g > MAX_GAIN) g = MAX_GAIN;
			if (g > UNITY && nblk < BOOST_HOLD) g = UNITY;
			gu = g;
			// dead zone around the present goal
			if (gu * 64'(COEF_ONE) < longint'(goal) * 64'(DZ_HI) &&
			    gu * 64'(COEF_ONE) > longint'(goal) * 64'(DZ_LO)) return;
			goal = g;
		endfunction

		function void close_block();
			longint unsigned mean;
			mean = blk_e / (fill != 0 ? fill : 1);
			blk_e = 0;
			fill = 0;
			if (mean <= ABS_GATE) return;
			if (nblk >= BLOCKS_MAX) return;
			if (nblk > 0 && mean * nblk * 10 < integ) return;
			integ = integ + mean;
			nblk++;
			blocks_kept++;
			retarget_gain();
		endfunction

		function frame_t process_frame(frame_t smp);
			int unsigned nc, look, bf, idx;
			longint atk, rel, mk, ceil_v, peak, desired, a, d, y;
			longint s [MAX_CH];
			longint unsigned sumsq;
			frame_t o;
			nc = regs.chans < 1 ? 1 : (regs.chans > MAX_CH ? MAX_CH : regs.chans);
			look = regs.look < 1 ? 1 : (regs.look > LA_DEPTH ? LA_DEPTH : regs.look);
			bf = regs.block < 1 ? 1 : regs.block;
			atk = regs.attack > COEF_ONE ? COEF_ONE : regs.attack;
			rel = regs.release_c > COEF_ONE ? COEF_ONE : regs.release_c;
			mk = regs.makeup > COEF_ONE ? COEF_ONE : regs.makeup;
			ceil_v = regs.ceil_lvl;
			sumsq = 0;
			peak = 0;
			for (int c = 0; c < nc; c++) begin
				s[c] = longint'($signed(smp[c]));
				sumsq = sumsq + longint'(s[c] * s[c]);
			end
			blk_e = blk_e + ((sumsq / nc) >> 15);
			fill++;
			if (fill >= bf) close_block();
			mk_gain = one_pole(mk_gain, goal, mk);
			for (int c = 0; c < nc; c++) begin
				s[c] = rnd_shift(s[c] * mk_gain, 20);
				a = s[c] < 0 ? -s[c] : s[c];
				if (a > peak) peak = a;
			end
			desired = (peak > ceil_v) ? (ceil_v * UNITY) / peak : UNITY;
			lim_gain = one_pole(lim_gain, desired, desired < lim_gain ? atk : rel);
			o = '0;
			for (int c = 0; c < nc; c++) begin
				idx = wslot * MAX_CH + c;
				d = dly[idx];
				dly[idx] = s[c];
				y = rnd_shift(d * lim_gain, 20);
				if (y > ceil_v) y = ceil_v;
				if (y < -ceil_v) y = -ceil_v;
				o[c] = y[SAMPLE_W-1:0];
			end
			wslot = (wslot + 1 >= look) ? 0 : wslot + 1;
			return o;
		endfunction

		function void take_request(kind_t k, frame_t smp);
			if (regs.enable != prev_en) begin
				clear_track();
				prev_en = regs.enable;
			end
			case (k)
				K_TRACK: begin
					clear_track();
					track_clears++;
				end
				K_TRANSPORT: begin
					clear_transport();
					transport_clears++;
				end
				K_FRAME: begin
					frames_in++;
					if (!regs.enable) pending_frames.push_back(smp);
					else pending_frames.push_back(process_frame(smp));
				end
				default: ;
			endcase
		endfunction

		function void check_frame(frame_t got);
			frame_t exp_f;
			frames_out++;
			if (pending_frames.size() == 0) begin
				errors++;
				$display("%0t: unexpected result frame %h", $time, got);
				return;
			end
			exp_f = pending_frames.pop_front();
			for (int c = 0; c < MAX_CH; c++)
				if (exp_f[c] !== got[c]) begin
					errors++;
					$display("%0t: out_ch%0d expected %0d got %0d", $time, c,
						$signed(exp_f[c]), $signed(got[c]));
				end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_write_en;
	logic [2:0] cfg_index;
	logic [24:0] cfg_data;
	logic item_valid, item_stall, result_valid, result_stall;
	logic [1:0] cmd;
	logic signed [SAMPLE_W-1:0] smp [MAX_CH];
	logic signed [SAMPLE_W-1:0] res [MAX_CH];

	loudness_normaliser_lookahead_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall), .cmd(cmd),
		.sample_ch0(smp[0]), .sample_ch1(smp[1]), .sample_ch2(smp[2]), .sample_ch3(smp[3]),
		.sample_ch4(smp[4]), .sample_ch5(smp[5]), .sample_ch6(smp[6]), .sample_ch7(smp[7]),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_ch0(res[0]), .out_ch1(res[1]), .out_ch2(res[2]), .out_ch3(res[3]),
		.out_ch4(res[4]), .out_ch5(res[5]), .out_ch6(res[6]), .out_ch7(res[7])
	);

	loudness_checker chk;
	bit calm;       // no idling on either side
	bit hold_req;   // ask the receiver for one long hold-off
	int cycles;
	int level_shift;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: accepted frames go straight to the checker
	always @(posedge clk) begin
		frame_t got;
		if (arst_n && result_valid && !result_stall) begin
			for (int c = 0; c < MAX_CH; c++) got[c] = res[c];
			chk.check_frame(got);
		end
	end

	// receiver stall: short random bursts, or one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (2500) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [24:0] v);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
		chk.set_reg(idx, v);
	endtask

	// hold one request until taken, then maybe leave a gap
	task automatic send_request(kind_t k, frame_t f);
		int gap;
		cmd <= k;
		for (int c = 0; c < MAX_CH; c++) smp[c] <= f[c];
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		chk.take_request(k, f);
		gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every expected frame, then let the block drain
	task automatic settle();
		item_valid <= 1'b0;
		while (chk.pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic frame_t fill_frame(logic signed [SAMPLE_W-1:0] v);
		frame_t f;
		for (int c = 0; c < MAX_CH; c++) f[c] = v;
		return f;
	endfunction

	function automatic frame_t audio_frame();
		frame_t f;
		logic signed [SAMPLE_W-1:0] v;
		for (int c = 0; c < MAX_CH; c++) begin
			v = SAMPLE_W'($urandom);
			case ($urandom_range(0, 15))
				0: f[c] = 24'sh7FFFFF;
				1: f[c] = 24'sh800000;
				2: f[c] = v;
				default: f[c] = v >>> level_shift;
			endcase
		end
		return f;
	endfunction

	function automatic kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 90) return K_FRAME;
		if (r < 94) return K_TRACK;
		if (r < 98) return K_TRANSPORT;
		return K_IGNORE;
	endfunction

	function automatic logic [24:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 25'd0;
			1: return COEF_ONE;
			2: return 25'($urandom_range(16777217, 33554431));
			3: return 25'($urandom_range(0, 16777216));
			default: return 25'($urandom_range(1 << 18, 16777216));
		endcase
	endfunction

	task automatic random_config();
		logic [7:0] lk;
		logic [19:0] bl;
		logic [22:0] cl;
		case ($urandom_range(0, 5))
			0: lk = 8'd0;
			1: lk = 8'd128;
			2: lk = 8'($urandom_range(129, 255));
			3: lk = 8'($urandom_range(1, 4));
			default: lk = 8'($urandom_range(1, 128));
		endcase
		case ($urandom_range(0, 7))
			0: bl = 20'd0;
			1: bl = 20'hFFFFF;
			2: bl = 20'($urandom_range(17, 200));
			default: bl = 20'($urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 5))
			0: cl = 23'h7FFFFF;
			1: cl = 23'($urandom_range(0, 255));
			default: cl = 23'($urandom_range(1 << 20, 8388607));
		endcase
		write_reg(REG_ENABLE, ($urandom_range(0, 5) == 0) ? 25'd0 : 25'd1);
		write_reg(REG_CHANS, ($urandom_range(0, 6) == 0) ? 25'($urandom_range(0, 15))
			: 25'($urandom_range(1, 8)));
		write_reg(REG_LOOK, 25'(lk));
		write_reg(REG_BLOCK, 25'(bl));
		write_reg(REG_ATTACK, pick_coef());
		write_reg(REG_RELEASE, pick_coef());
		write_reg(REG_MAKEUP, pick_coef());
		write_reg(REG_CEIL, 25'(cl));
	endtask

	initial begin
		chk = new();
		calm = 0;
		hold_req = 0;
		cycles = 0;
		level_shift = 4;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		item_valid = 1'b0;
		cmd = K_FRAME;
		for (int c = 0; c < MAX_CH; c++) smp[c] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bypass after reset: extremes pass unchanged, commands give nothing
		send_request(K_FRAME, fill_frame(24'sh7FFFFF));
		send_request(K_FRAME, fill_frame(24'sh800000));
		send_request(K_TRACK, '0);
		send_request(K_TRANSPORT, '0);
		send_request(K_IGNORE, audio_frame());
		send_request(K_FRAME, audio_frame());
		settle();

		// zero counts and lengths act as one, coefficients above unity saturate,
		// zero ceiling forces silence
		write_reg(REG_ENABLE, 25'd1);
		write_reg(REG_CHANS, 25'd0);
		write_reg(REG_LOOK, 25'd0);
		write_reg(REG_BLOCK, 25'd0);
		write_reg(REG_ATTACK, 25'h1FFFFFF);
		write_reg(REG_RELEASE, 25'd0);
		write_reg(REG_MAKEUP, 25'h1FFFFFF);
		write_reg(REG_CEIL, 25'd0);
		send_request(K_FRAME, fill_frame(24'sh7FFFFF));
		send_request(K_FRAME, fill_frame(24'sh800000));
		send_request(K_FRAME, audio_frame());
		send_request(K_TRACK, '0);
		send_request(K_FRAME, audio_frame());
		send_request(K_TRANSPORT, '0);
		send_request(K_FRAME, audio_frame());
		settle();

		// oversized channel count and look-ahead, longest block, full-scale ceiling
		write_reg(REG_CHANS, 25'd15);
		write_reg(REG_LOOK, 25'd255);
		write_reg(REG_BLOCK, 25'hFFFFF);
		write_reg(REG_ATTACK, COEF_ONE);
		write_reg(REG_RELEASE, COEF_ONE);
		write_reg(REG_MAKEUP, 25'd0);
		write_reg(REG_CEIL, 25'h7FFFFF);
		send_request(K_FRAME, fill_frame(24'sh7FFFFF));
		send_request(K_FRAME, fill_frame(24'sh800000));
		for (int i = 0; i < 4; i++) send_request(K_FRAME, audio_frame());
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			random_config();
			// idling off for the closing phases and now and then elsewhere
			calm = (p >= RAND_PHASES - 2) || ($urandom_range(0, 4) == 0);
			if (p == 3) begin
				// long receiver hold-off with back-to-back requests to fill the block
				calm = 1;
				hold_req = 1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// loudness moves in segments so both gates and the dead zone get hit
				if (i % 20 == 0) level_shift = $urandom_range(0, 22);
				send_request(pick_kind(), audio_frame());
			end
			settle();
		end

		$display("checked %0d of %0d frames; %0d blocks passed the gates", chk.frames_out,
			chk.frames_in, chk.blocks_kept);
		$display("track clears %0d, transport clears %0d, %0d mismatches",
			chk.track_clears, chk.transport_clears, chk.errors);
		if (chk.errors == 0 && chk.pending_frames.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
